@@ rtl/fcl_pkg.sv @@
package fcl_pkg;

    // Default sizes of the stores
    localparam int unsigned MAX_IN_DEF  = 1024;
    localparam int unsigned MAX_OUT_DEF = 64;

    // Field and register widths
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned OUT_IDX_W  = 6;
    localparam int unsigned IN_IDX_W   = 10;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned BIAS_W     = 32;
    localparam int unsigned SUM_W      = 48;
    localparam int unsigned IN_LEN_W   = 11;
    localparam int unsigned OUT_CNT_W  = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    // Product and accumulator widths (two guard bits over the result)
    localparam int unsigned PROD_W = 2 * SAMPLE_W;
    localparam int unsigned ACC_W  = SUM_W + 2;

    // Transaction modes
    localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ELEM   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IN_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN   = 2'd2;

    // Control from the sequencer to the MAC unit
    typedef struct packed {
        logic vld;      // weight and element read data valid
        logic init;     // load accumulator with the start value
        logic bias_en;  // start value is the bias, else zero
    } t_mac_ctl;

    // Status from the MAC unit back to the sequencer
    typedef struct packed {
        logic             busy;  // a product still heads for the accumulator
        logic [SUM_W-1:0] sum;   // clipped sum
        logic             sat;   // sum was clipped
    } t_mac_st;

endpackage

@@ rtl/fcl_mac.sv @@
module fcl_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fcl_pkg::t_mac_ctl                i_ctl,
    input  logic signed [fcl_pkg::SAMPLE_W-1:0] i_w,
    input  logic signed [fcl_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [fcl_pkg::BIAS_W-1:0]   i_bias,
    output fcl_pkg::t_mac_st                 o_st
);
    import fcl_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     w_pos_ovf;
    logic                     w_neg_ovf;

    // Register the product of one weight and one element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
        r_prod <= PROD_W'(i_w) * PROD_W'(i_x);
    end

    // Start from bias or zero, then add each product
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_acc <= i_ctl.bias_en ? ACC_W'(i_bias) : '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Clip to the signed result range
    assign w_pos_ovf = !r_acc[ACC_W-1] && (r_acc[ACC_W-2:SUM_W-1] != '0);
    assign w_neg_ovf = r_acc[ACC_W-1] && (r_acc[ACC_W-2:SUM_W-1] != '1);

    always_comb begin
        o_st.busy = r_prod_vld;
        o_st.sat  = w_pos_ovf || w_neg_ovf;
        if (w_pos_ovf) begin
            o_st.sum = {1'b0, {(SUM_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            o_st.sum = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            o_st.sum = r_acc[SUM_W-1:0];
        end
    end

endmodule

@@ rtl/fully_connected_layer_top.sv @@
// Fully connected layer: matrix-vector multiply with optional bias.
// Input channel (i_valid / o_stall) carries one transaction per write:
// mode 0 stores a weight at (out_index, in_index), mode 1 stores a bias
// at out_index, mode 2 stores a vector element at in_index. The element
// at index in_len-1 starts a pass that emits out_count results on the
// output channel (o_valid / i_stall), neurons in order, last set on the
// final one.
// A pass runs one shared 16x16 multiplier and 50-bit accumulator over
// every (neuron, element) pair, reading weights through the single
// weight memory read port. o_stall is high for the whole pass.
// The result register frees the MAC: the next neuron is computed while a
// result waits; if the receiver stalls, the sequencer holds at the end of
// a neuron until the register is taken.
// Synchronous reset clears the sequencer and sets in_len = 1,
// out_count = 1, bias off. Weight, bias and vector stores are not cleared
// and must be written before they are used.
module fully_connected_layer_top #(
    parameter int unsigned MAX_IN  = fcl_pkg::MAX_IN_DEF,
    parameter int unsigned MAX_OUT = fcl_pkg::MAX_OUT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [fcl_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [fcl_pkg::MODE_W-1:0]             i_mode,
    input  logic [fcl_pkg::OUT_IDX_W-1:0]          i_out_index,
    input  logic [fcl_pkg::IN_IDX_W-1:0]           i_in_index,
    input  logic signed [fcl_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic signed [fcl_pkg::BIAS_W-1:0]      i_bias_value,
    // output channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [fcl_pkg::OUT_IDX_W-1:0]          o_neuron_index,
    output logic signed [fcl_pkg::SUM_W-1:0]       o_sum,
    output logic                                   o_saturated,
    output logic                                   o_last
);
    import fcl_pkg::*;

    localparam int unsigned IN_AW  = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
    localparam int unsigned OUT_AW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int unsigned W_DEPTH = MAX_IN * MAX_OUT;
    localparam int unsigned W_AW   = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int unsigned LEN_MAX_U =
        (MAX_IN > ((1 << IN_LEN_W) - 1)) ? ((1 << IN_LEN_W) - 1) : MAX_IN;
    localparam logic [IN_LEN_W-1:0]  LEN_MAX = IN_LEN_W'(LEN_MAX_U);
    localparam logic [OUT_CNT_W-1:0] CNT_MAX = OUT_CNT_W'(MAX_OUT);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_MAC   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    // Stores
    logic [SAMPLE_W-1:0] r_weight_mem [W_DEPTH];
    logic [BIAS_W-1:0]   r_bias_mem   [MAX_OUT];
    logic [SAMPLE_W-1:0] r_vec_mem    [MAX_IN];

    // Configuration
    logic [IN_LEN_W-1:0]  r_in_len;
    logic [OUT_CNT_W-1:0] r_out_count;
    logic                 r_bias_en;

    // Sequencer
    t_state              r_state;
    t_state              n_state;
    logic [OUT_AW-1:0]   r_p;
    logic [IN_AW-1:0]    r_q;
    logic [W_AW-1:0]     r_row_base;
    logic                r_rd_vld;
    logic signed [SAMPLE_W-1:0] r_w;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [BIAS_W-1:0]   r_bias;

    // Result register
    logic                 r_o_valid;
    logic [OUT_IDX_W-1:0] r_o_neuron;
    logic [SUM_W-1:0]     r_o_sum;
    logic                 r_o_sat;
    logic                 r_o_last;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_in_ok;
    logic                 w_out_ok;
    logic                 w_start;
    logic                 w_q_last;
    logic                 w_p_last;
    logic                 w_emit;
    logic [IN_LEN_W-1:0]  w_len;
    logic [OUT_CNT_W-1:0] w_cnt;
    logic [W_AW-1:0]      w_wr_addr;
    t_mac_ctl             w_ctl;
    t_mac_st              w_st;

    // Effective length and count, clamped to 1 .. max
    always_comb begin
        if (r_in_len == '0) begin
            w_len = IN_LEN_W'(1);
        end else if (r_in_len > LEN_MAX) begin
            w_len = LEN_MAX;
        end else begin
            w_len = r_in_len;
        end
        if (r_out_count == '0) begin
            w_cnt = OUT_CNT_W'(1);
        end else if (r_out_count > CNT_MAX) begin
            w_cnt = CNT_MAX;
        end else begin
            w_cnt = r_out_count;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_in_ok    = 32'(i_in_index) < MAX_IN;
    assign w_out_ok   = 32'(i_out_index) < MAX_OUT;
    assign w_start    = w_in_acc && (i_mode == MODE_ELEM) && w_in_ok &&
                        (IN_LEN_W'(i_in_index) == w_len - IN_LEN_W'(1));
    assign w_q_last   = (32'(r_q) == 32'(w_len - IN_LEN_W'(1)));
    assign w_p_last   = (OUT_CNT_W'(r_p) == w_cnt - OUT_CNT_W'(1));
    assign w_emit     = (r_state == S_DRAIN) && !r_rd_vld && !w_st.busy && w_out_free;
    assign w_wr_addr  = W_AW'(32'(i_out_index) * MAX_IN + 32'(i_in_index));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_len    <= IN_LEN_W'(1);
            r_out_count <= OUT_CNT_W'(1);
            r_bias_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IN_LEN:    r_in_len    <= i_cfg_data[IN_LEN_W-1:0];
                CFG_OUT_COUNT: r_out_count <= i_cfg_data[OUT_CNT_W-1:0];
                CFG_BIAS_EN:   r_bias_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Store writes from accepted transactions
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_mode == MODE_WEIGHT) && w_out_ok && w_in_ok) begin
            r_weight_mem[w_wr_addr] <= i_sample;
        end
        if (w_in_acc && (i_mode == MODE_BIAS) && w_out_ok) begin
            r_bias_mem[OUT_AW'(i_out_index)] <= i_bias_value;
        end
        if (w_in_acc && (i_mode == MODE_ELEM) && w_in_ok) begin
            r_vec_mem[IN_AW'(i_in_index)] <= i_sample;
        end
    end

    // Registered store reads for the MAC
    always_ff @(posedge i_clk) begin
        r_w    <= r_weight_mem[r_row_base + W_AW'(r_q)];
        r_x    <= r_vec_mem[r_q];
        r_bias <= r_bias_mem[r_p];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_start) n_state = S_START;
            S_START: n_state = S_MAC;
            S_MAC:   if (w_q_last) n_state = S_DRAIN;
            S_DRAIN: if (w_emit) n_state = w_p_last ? S_IDLE : S_START;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers: walk neurons and elements
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_MAC);
        end
        unique case (r_state)
            S_IDLE: begin
                r_p        <= '0;
                r_q        <= '0;
                r_row_base <= '0;
            end
            S_START: begin
                r_q <= '0;
            end
            S_MAC: begin
                r_q <= r_q + IN_AW'(1);
            end
            S_DRAIN: begin
                if (w_emit) begin
                    r_p        <= r_p + OUT_AW'(1);
                    r_row_base <= r_row_base + W_AW'(MAX_IN);
                end
            end
            default: ;
        endcase
    end

    // MAC unit control
    always_comb begin
        w_ctl.vld     = r_rd_vld;
        w_ctl.init    = (r_state == S_MAC) && (r_q == '0);
        w_ctl.bias_en = r_bias_en;
    end

    fcl_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_w     (r_w),
        .i_x     (r_x),
        .i_bias  (r_bias),
        .o_st    (w_st)
    );

    // Result register: load at end of neuron, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
        if (w_emit) begin
            r_o_neuron <= OUT_IDX_W'(r_p);
            r_o_sum    <= w_st.sum;
            r_o_sat    <= w_st.sat;
            r_o_last   <= w_p_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_neuron_index = r_o_neuron;
    assign o_sum          = r_o_sum;
    assign o_saturated    = r_o_sat;
    assign o_last         = r_o_last;

endmodule

@@ test/tb_fully_connected_layer_top.sv @@
module tb_fully_connected_layer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcl_pkg::*;

    localparam int unsigned N_ITEMS     = 330;
    localparam int unsigned QUIET_LIMIT = 50000;
    localparam int unsigned SETTLE_CYC  = 24;
    localparam int unsigned HOLD_CYC    = 600;
    localparam int unsigned MAX_ERR_LOG = 10;

    // Unused mode code, the block drops it
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [OUT_IDX_W-1:0] out_index;
        logic [IN_IDX_W-1:0]  in_index;
        logic [SAMPLE_W-1:0]  sample;
        logic [BIAS_W-1:0]    bias_value;
    } t_layer_txn;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] neuron;
        logic [SUM_W-1:0]     sum;
        logic                 sat;
        logic                 last;
    } t_neuron_sum;

    typedef enum logic {ROW_TXN, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        t_layer_txn             txn;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_data;
        bit                     typed;
        logic [SUM_W-1:0]       typed_sum;
    } t_stim_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        i_valid;
    logic                        o_stall;
    logic [MODE_W-1:0]           i_mode;
    logic [OUT_IDX_W-1:0]        i_out_index;
    logic [IN_IDX_W-1:0]         i_in_index;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic signed [BIAS_W-1:0]    i_bias_value;
    logic                        o_valid;
    logic                        i_stall;
    logic [OUT_IDX_W-1:0]        o_neuron_index;
    logic signed [SUM_W-1:0]     o_sum;
    logic                        o_saturated;
    logic                        o_last;

    fully_connected_layer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_out_index    (i_out_index),
        .i_in_index     (i_in_index),
        .i_sample       (i_sample),
        .i_bias_value   (i_bias_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_neuron_index (o_neuron_index),
        .o_sum          (o_sum),
        .o_saturated    (o_saturated),
        .o_last         (o_last)
    );

    // Layer state as the testbench predicts it
    logic [SAMPLE_W-1:0]  wt_mem   [0:MAX_IN_DEF*MAX_OUT_DEF-1];
    bit                   wt_set   [0:MAX_IN_DEF*MAX_OUT_DEF-1];
    logic [BIAS_W-1:0]    bias_mem [0:MAX_OUT_DEF-1];
    bit                   bias_set [0:MAX_OUT_DEF-1];
    logic [SAMPLE_W-1:0]  vec_mem  [0:MAX_IN_DEF-1];
    bit                   vec_set  [0:MAX_IN_DEF-1];
    logic [IN_LEN_W-1:0]  len_reg  = IN_LEN_W'(1);
    logic [OUT_CNT_W-1:0] cnt_reg  = OUT_CNT_W'(1);
    logic                 bias_on  = 1'b0;

    t_neuron_sum pending_sums[$];
    t_stim_row   dir_rows[$];

    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_count   = 0;
    bit          rx_hold_req  = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned active_len();
        if (len_reg == '0) return 1;
        if (32'(len_reg) > MAX_IN_DEF) return MAX_IN_DEF;
        return 32'(len_reg);
    endfunction

    function automatic int unsigned active_cnt();
        if (cnt_reg == '0) return 1;
        if (32'(cnt_reg) > MAX_OUT_DEF) return MAX_OUT_DEF;
        return 32'(cnt_reg);
    endfunction

    // Idling: sender light / receiver heavy, then swapped, then none
    function automatic int unsigned idle_regime();
        if (sent_count < N_ITEMS / 3) return 0;
        if (sent_count < 2 * N_ITEMS / 3) return 1;
        return 2;
    endfunction

    function automatic bit sender_gap();
        case (idle_regime())
            0: return $urandom_range(0, 99) < 38;
            1: return $urandom_range(0, 99) < 56;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (idle_regime())
            0: return $urandom_range(0, 99) < 56;
            1: return $urandom_range(0, 99) < 38;
            default: return 1'b0;
        endcase
    endfunction

    // Queue one result per neuron: bias plus dot product, clipped to 48 bits
    function automatic void compute_layer_pass();
        int unsigned len;
        int unsigned cnt;
        longint      acc;
        bit          sat;
        t_neuron_sum r;
        len = active_len();
        cnt = active_cnt();
        for (int unsigned p = 0; p < cnt; p++) begin
            acc = bias_on ? longint'($signed(bias_mem[p])) : 64'sd0;
            for (int unsigned q = 0; q < len; q++) begin
                acc += longint'($signed(wt_mem[p * MAX_IN_DEF + q]))
                     * longint'($signed(vec_mem[q]));
            end
            sat = 1'b0;
            if (acc > SUM_HI) begin
                acc = SUM_HI;
                sat = 1'b1;
            end
            if (acc < SUM_LO) begin
                acc = SUM_LO;
                sat = 1'b1;
            end
            r = '{neuron: p[OUT_IDX_W-1:0], sum: acc[SUM_W-1:0], sat: sat,
                  last: (p == cnt - 1)};
            pending_sums.push_back(r);
        end
    endfunction

    // Apply one accepted transaction to the stores; return 1 if it starts a pass
    function automatic bit record_txn(t_layer_txn t);
        case (t.mode)
            MODE_WEIGHT: begin
                wt_mem[{t.out_index, t.in_index}] = t.sample;
                wt_set[{t.out_index, t.in_index}] = 1'b1;
            end
            MODE_BIAS: begin
                bias_mem[t.out_index] = t.bias_value;
                bias_set[t.out_index] = 1'b1;
            end
            MODE_ELEM: begin
                vec_mem[t.in_index] = t.sample;
                vec_set[t.in_index] = 1'b1;
                return int'(t.in_index) == int'(active_len()) - 1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_layer_txn make_txn(input logic [MODE_W-1:0] mode,
                                            input logic [OUT_IDX_W-1:0] oi,
                                            input logic [IN_IDX_W-1:0] ii,
                                            input logic [SAMPLE_W-1:0] smp,
                                            input logic [BIAS_W-1:0] bv);
        t_layer_txn t;
        t = '{mode: mode, out_index: oi, in_index: ii, sample: smp, bias_value: bv};
        return t;
    endfunction

    function automatic t_stim_row txn_row(input logic [MODE_W-1:0] mode,
                                          input logic [OUT_IDX_W-1:0] oi,
                                          input logic [IN_IDX_W-1:0] ii,
                                          input logic [SAMPLE_W-1:0] smp,
                                          input logic [BIAS_W-1:0] bv,
                                          input bit typed,
                                          input logic [SUM_W-1:0] s);
        t_stim_row row;
        row.kind      = ROW_TXN;
        row.txn       = make_txn(mode, oi, ii, smp, bv);
        row.cfg_idx   = '0;
        row.cfg_data  = '0;
        row.typed     = typed;
        row.typed_sum = s;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row.kind      = ROW_CFG;
        row.txn       = '0;
        row.cfg_idx   = idx;
        row.cfg_data  = data;
        row.typed     = 1'b0;
        row.typed_sum = '0;
        return row;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_ERR_LOG) $display("mismatch: %s", msg);
    endfunction

    // Offer one transaction, hold it until accepted, then predict its results
    task automatic send_txn(input t_layer_txn t, input bit typed,
                            input logic [SUM_W-1:0] typed_sum);
        t_neuron_sum r;
        while (sender_gap()) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_mode       = t.mode;
        i_out_index  = t.out_index;
        i_in_index   = t.in_index;
        i_sample     = t.sample;
        i_bias_value = t.bias_value;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (record_txn(t)) begin
            if (typed) begin
                r = '{neuron: '0, sum: typed_sum, sat: 1'b0, last: 1'b1};
                pending_sums.push_back(r);
            end else begin
                compute_layer_pass();
            end
        end
        @(negedge i_clk);
    endtask

    // Write a register once every result is out and the block has settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_valid = 1'b0;
        while (pending_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_IN_LEN:    len_reg = data[IN_LEN_W-1:0];
            CFG_OUT_COUNT: cnt_reg = data[OUT_CNT_W-1:0];
            CFG_BIAS_EN:   bias_on = data[0];
            default: ;
        endcase
    endtask

    // One setting: fill every entry a pass reads, then random traffic
    task automatic run_phase(input logic [IN_LEN_W-1:0] len_val,
                             input logic [OUT_CNT_W-1:0] cnt_val,
                             input logic bias_val, input int unsigned steps);
        int unsigned len;
        int unsigned cnt;
        int unsigned r;
        write_reg(CFG_IN_LEN, len_val);
        write_reg(CFG_OUT_COUNT, CFG_DATA_W'(cnt_val));
        write_reg(CFG_BIAS_EN, CFG_DATA_W'(bias_val));
        len = active_len();
        cnt = active_cnt();
        for (int unsigned p = 0; p < cnt; p++) begin
            if (!bias_set[p])
                send_txn(make_txn(MODE_BIAS, OUT_IDX_W'(p), IN_IDX_W'($urandom),
                                  SAMPLE_W'($urandom), $urandom), 1'b0, '0);
            for (int unsigned q = 0; q < len; q++) begin
                if (!wt_set[p * MAX_IN_DEF + q])
                    send_txn(make_txn(MODE_WEIGHT, OUT_IDX_W'(p), IN_IDX_W'(q),
                                      SAMPLE_W'($urandom), $urandom), 1'b0, '0);
            end
        end
        for (int unsigned q = 0; q + 1 < len; q++) begin
            if (!vec_set[q])
                send_txn(make_txn(MODE_ELEM, OUT_IDX_W'($urandom), IN_IDX_W'(q),
                                  SAMPLE_W'($urandom), $urandom), 1'b0, '0);
        end
        for (int unsigned s = 0; s < steps; s++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // Well-formed vector ending on the trigger element
                if (len <= 16) begin
                    for (int unsigned q = 0; q < len; q++) begin
                        send_txn(make_txn(MODE_ELEM, OUT_IDX_W'($urandom), IN_IDX_W'(q),
                                          SAMPLE_W'($urandom), $urandom), 1'b0, '0);
                    end
                end else begin
                    repeat (6) begin
                        send_txn(make_txn(MODE_ELEM, OUT_IDX_W'($urandom),
                                          IN_IDX_W'($urandom_range(0, len - 2)),
                                          SAMPLE_W'($urandom), $urandom), 1'b0, '0);
                    end
                    send_txn(make_txn(MODE_ELEM, OUT_IDX_W'($urandom), IN_IDX_W'(len - 1),
                                      SAMPLE_W'($urandom), $urandom), 1'b0, '0);
                end
            end else if (r < 70) begin
                send_txn(make_txn(MODE_WEIGHT, OUT_IDX_W'($urandom), IN_IDX_W'($urandom),
                                  SAMPLE_W'($urandom), $urandom), 1'b0, '0);
            end else if (r < 78) begin
                send_txn(make_txn(MODE_BIAS, OUT_IDX_W'($urandom), IN_IDX_W'($urandom),
                                  SAMPLE_W'($urandom), $urandom), 1'b0, '0);
            end else if (r < 90) begin
                // Any position, often past the vector length
                send_txn(make_txn(MODE_ELEM, OUT_IDX_W'($urandom), IN_IDX_W'($urandom),
                                  SAMPLE_W'($urandom), $urandom), 1'b0, '0);
            end else begin
                send_txn(make_txn(MODE_NONE, OUT_IDX_W'($urandom), IN_IDX_W'($urandom),
                                  SAMPLE_W'($urandom), $urandom), 1'b0, '0);
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off while results wait
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && o_valid) begin
                i_stall = 1'b1;
                repeat (HOLD_CYC) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            i_stall = receiver_gap();
        end
    end

    // Check results against the oldest prediction; watch for a hung block
    always @(posedge i_clk) begin
        t_neuron_sum want;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (i_rst_n && o_valid && !i_stall) begin
            if (pending_sums.size() == 0) begin
                note_mismatch($sformatf("unexpected result neuron %0d sum %h last %b",
                                        o_neuron_index, o_sum, o_last));
            end else begin
                want = pending_sums.pop_front();
                if (o_neuron_index !== want.neuron || o_sum !== want.sum
                        || o_saturated !== want.sat || o_last !== want.last)
                    note_mismatch($sformatf(
                        "neuron %0d/%0d sum %h/%h sat %b/%b last %b/%b (exp/got)",
                        want.neuron, o_neuron_index, want.sum, o_sum,
                        want.sat, o_saturated, want.last, o_last));
            end
        end
    end

    // Stimulus
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_mode       = '0;
        i_out_index  = '0;
        i_in_index   = '0;
        i_sample     = '0;
        i_bias_value = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: extremes, every mode, ignored and non-triggering writes
        dir_rows.push_back(txn_row(MODE_WEIGHT, 6'd0, 10'd0, 16'h7FFF, 32'd0, 1'b0, '0));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h7FFF, 32'd0, 1'b1,
                                   48'sd1073676289));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h8000, 32'd0, 1'b1,
                                   -48'sd1073709056));
        dir_rows.push_back(txn_row(MODE_WEIGHT, 6'd0, 10'd0, 16'h8000, 32'd0, 1'b0, '0));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h8000, 32'd0, 1'b1,
                                   48'sd1073741824));
        dir_rows.push_back(txn_row(MODE_NONE, 6'd63, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF,
                                   1'b0, '0));
        dir_rows.push_back(txn_row(MODE_WEIGHT, 6'd63, 10'd1023, 16'h7FFF, 32'd0, 1'b0, '0));
        dir_rows.push_back(txn_row(MODE_BIAS, 6'd63, 10'd0, 16'h0000, 32'h7FFF_FFFF,
                                   1'b0, '0));
        dir_rows.push_back(txn_row(MODE_BIAS, 6'd0, 10'd0, 16'h0000, 32'h8000_0000,
                                   1'b0, '0));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd1023, 16'h1234, 32'd0, 1'b0, '0));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h0000, 32'd0, 1'b1, '0));
        dir_rows.push_back(cfg_row(CFG_BIAS_EN, 11'd1));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h0000, 32'd0, 1'b1,
                                   -48'sd2147483648));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h0001, 32'd0, 1'b0, '0));
        dir_rows.push_back(cfg_row(CFG_OUT_COUNT, 11'd0));
        dir_rows.push_back(cfg_row(CFG_IN_LEN, 11'd0));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h7FFF, 32'd0, 1'b0, '0));
        dir_rows.push_back(txn_row(MODE_BIAS, 6'd1, 10'd0, 16'h0000, 32'h0000_0001,
                                   1'b0, '0));
        dir_rows.push_back(txn_row(MODE_WEIGHT, 6'd1, 10'd0, 16'h0002, 32'd0, 1'b0, '0));
        dir_rows.push_back(cfg_row(CFG_OUT_COUNT, 11'd2));
        dir_rows.push_back(txn_row(MODE_ELEM, 6'd0, 10'd0, 16'h0003, 32'd0, 1'b0, '0));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                write_reg(dir_rows[k].cfg_idx, dir_rows[k].cfg_data);
            else
                send_txn(dir_rows[k].txn, dir_rows[k].typed, dir_rows[k].typed_sum);
        end

        // Largest count with a long receiver hold-off, then a count above it
        rx_hold_req = 1'b1;
        run_phase(11'd1, 7'd64, 1'b1, 14);
        run_phase(11'd1, 7'd127, 1'b0, 8);

        // Mostly small sizes from here on
        while (sent_count < N_ITEMS) begin
            run_phase(($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8)),
                      ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 8)),
                      1'($urandom_range(0, 1)), 12);
        end

        // Drain, let the block settle, report
        i_valid = 1'b0;
        while (pending_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
